// File: src/ggc_pkg.sv
// Package for the greedy garbage-collection victim selector.
// Holds table sizes, request and response types, datapath command and status, and FSM states.
// No dependencies.
package ggc_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS      = 1024;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int IDX_W           = 10;
    localparam int VP_W            = 7;

    // Request function codes.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    // One request as it enters the block.
    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  block_index;
        logic              is_data_block;
        logic [VP_W-1:0]   valid_pages;
    } t_ggc_req;

    // One result of a select request.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  victim_block;
        logic [VP_W-1:0]   victim_valid_pages;
    } t_ggc_rsp;

    // One table entry.
    typedef struct packed {
        logic              data;
        logic [VP_W-1:0]   valid;
    } t_blk_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;    // write zero at the sweep address and advance
        logic table_wr;    // store the request's entry
        logic scan_start;  // reset the sweep address and the running best
        logic scan_rd;     // read the entry at the sweep address and advance
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_last;   // sweep address is at the final entry
        logic zero_hit;    // compare stage just chose a block with no valid pages
    } t_dp_sts;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_ggc_state;

endpackage

// File: src/greedy_gc_victim_selector.sv
// Greedy GC victim selector top level. A write request is stored in the table and busy stays low.
// A select scans one table entry per cycle; o_done pulses once the scan has covered all
// NUM_BLOCKS entries, or as soon as it finds a data block with no valid pages.
// The single-port table read sets this rate. The receiver cannot stall.
// After reset the table is cleared by a sweep over all NUM_BLOCKS (1024) entries with busy high.
// Depends on ggc_pkg, ggc_ctrl and ggc_dp.
module greedy_gc_victim_selector import ggc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_ggc_req i_req,
    output logic     busy,
    output logic     o_done,
    output t_ggc_rsp o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller.
    ggc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_req.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // Datapath.
    ggc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

// File: src/ggc_ctrl.sv
// Controller state machine of the victim selector.
// Sequences the table clearing sweep, table writes and the select scan.
// Depends on ggc_pkg.
module ggc_ctrl import ggc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_func,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy,
    output logic    o_done
);

    t_ggc_state r_state;
    t_ggc_state n_state;
    logic       accept;

    assign accept = start && (r_state == ST_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.addr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (i_func == FUNC_SELECT)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // A block with no valid pages cannot be beaten, so stop there.
                if (i_sts.zero_hit) begin
                    n_state = ST_DONE;
                end else if (i_sts.addr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                busy             = 1'b0;
                o_cmd.table_wr   = accept && (i_func == FUNC_WRITE);
                o_cmd.scan_start = accept && (i_func == FUNC_SELECT);
            end
            ST_SCAN: begin
                o_cmd.scan_rd = !i_sts.zero_hit;
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: src/ggc_dp.sv
// Datapath of the victim selector: block table memory, sweep counter and running minimum.
// Driven by command signals from ggc_ctrl.
// Depends on ggc_pkg.
module ggc_dp import ggc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ggc_req i_req,
    input  t_dp_cmd  i_cmd,
    output t_dp_sts  o_sts,
    output t_ggc_rsp o_rsp
);

    t_blk_entry       mem [NUM_BLOCKS];
    logic [IDX_W-1:0] r_addr;
    t_blk_entry       r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    logic [VP_W-1:0]  r_best_cnt;
    logic [IDX_W-1:0] r_best_idx;
    logic             r_have;
    logic             better;

    // Table memory: clearing sweep, request writes, scan reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            mem[r_addr] <= '0;
        end else if (i_cmd.table_wr) begin
            mem[i_req.block_index] <= '{data: i_req.is_data_block, valid: i_req.valid_pages};
        end
        r_rd_data <= mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    // Sweep address and read-valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_addr <= '0;
            end else if (i_cmd.clear_wr || i_cmd.scan_rd) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            r_rd_vld <= i_cmd.scan_rd;
        end
    end

    // Compare stage: a strict compare keeps the lowest index on a tie.
    assign better = r_rd_vld && r_rd_data.data && (r_rd_data.valid < r_best_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_have <= 1'b0;
        end else if (better) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_best_cnt <= VP_W'(PAGES_PER_BLOCK);
            r_best_idx <= '0;
        end else if (better) begin
            r_best_cnt <= r_rd_data.valid;
            r_best_idx <= r_rd_idx;
        end
    end

    // Status to the controller.
    assign o_sts.addr_last = (r_addr == IDX_W'(NUM_BLOCKS - 1));
    assign o_sts.zero_hit  = better && (r_rd_data.valid == '0);

    // Result; all fields read zero when no block qualified.
    assign o_rsp.found              = r_have;
    assign o_rsp.victim_block       = r_have ? r_best_idx : '0;
    assign o_rsp.victim_valid_pages = r_have ? r_best_cnt : '0;

endmodule
